// ===== rtl/core/blg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// blg_pkg
// Shared widths and controller/datapath handshake types for the line pixel
// generator.
// ----------------------------------------------------------------------------
package blg_pkg;

  localparam int COORD_BITS_DEF = 6;
  localparam int COLOR_BITS     = 32;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;   // latch a new line word
    logic setup;  // order endpoints, form deltas and initial error
    logic step;   // emit one pixel and advance the walk
  } blg_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic zero_len;  // latched endpoints coincide
    logic at_end;    // walk sits on the final pixel
    logic out_free;  // output register can take a pixel this cycle
  } blg_sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/blg_ifs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// blg_line_if / blg_pixel_if
// Valid/ready channels for line commands and emitted pixels.
// ----------------------------------------------------------------------------
interface blg_line_if #(
  parameter int COORD_BITS = blg_pkg::COORD_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [COORD_BITS-1:0]         start_x;
  logic [COORD_BITS-1:0]         start_y;
  logic [COORD_BITS-1:0]         end_x;
  logic [COORD_BITS-1:0]         end_y;
  logic [blg_pkg::COLOR_BITS-1:0] line_color;

  modport source (output valid, start_x, start_y, end_x, end_y, line_color, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, line_color, output ready);
endinterface

interface blg_pixel_if #(
  parameter int COORD_BITS = blg_pkg::COORD_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [COORD_BITS-1:0]         pixel_x;
  logic [COORD_BITS-1:0]         pixel_y;
  logic [blg_pkg::COLOR_BITS-1:0] pixel_color;
  logic                          last_pixel;

  modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_color, last_pixel, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/bresenham_line_pixel_generator.sv =====
`default_nettype none
// After a line word is accepted, SETUP orders its endpoints (a zero-length line
// skips the walk); each WALK step then loads one pixel word into the output
// register, one pixel per cycle along the major axis while the output does not
// stall. A line holds the block through accept, setup and up to 64 walk steps.
// The walk is paced by the single output register; a stall on the output holds it.
// Reset: synchronous, active low; clears the sequencer and output valid only.
// ----------------------------------------------------------------------------
// bresenham_line_pixel_generator
// Takes a line word (two tile-local endpoints and a colour) and emits the
// line's pixels with Bresenham's integer error term.
// ----------------------------------------------------------------------------
module bresenham_line_pixel_generator #(
  parameter int COORD_BITS = blg_pkg::COORD_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  blg_line_if.sink    in_line,
  blg_pixel_if.source out_pix
);
  import blg_pkg::*;

  // Command and status between the sequencer and the datapath
  blg_cmd_t cmd;
  blg_sts_t sts;

  // Sequencer: IDLE takes a word, SETUP orders the endpoints (and drops a
  // zero-length line), WALK emits a pixel whenever the output register frees.
  // Ready rises again as soon as the final pixel is loaded, so the next line
  // word is taken while that pixel still waits downstream.
  blg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_line.valid),
    .in_ready (in_line.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: latch the word, pick the major axis (y on exact diagonals),
  // order endpoints so the major coordinate rises, then step the error term.
  blg_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_start_x      (in_line.start_x),
    .in_start_y      (in_line.start_y),
    .in_end_x        (in_line.end_x),
    .in_end_y        (in_line.end_y),
    .in_line_color   (in_line.line_color),
    .out_valid       (out_pix.valid),
    .out_ready       (out_pix.ready),
    .out_pixel_x     (out_pix.pixel_x),
    .out_pixel_y     (out_pix.pixel_y),
    .out_pixel_color (out_pix.pixel_color),
    .out_last_pixel  (out_pix.last_pixel)
  );

endmodule
`default_nettype wire

// ===== rtl/core/blg_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// blg_ctrl
// Sequencer: take a line word, run the setup state, then walk pixels unless the line has zero length.
// ----------------------------------------------------------------------------
module blg_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire blg_pkg::blg_sts_t sts,
  output blg_pkg::blg_cmd_t      cmd
);
  import blg_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SETUP = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        // drop lines with coincident endpoints
        state_nxt = sts.zero_len ? ST_IDLE : ST_WALK;
      end
      ST_WALK: begin
        if (sts.out_free) begin
          cmd.step = 1'b1;
          if (sts.at_end) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/blg_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// blg_dp
// Endpoint ordering, Bresenham error walk and the pixel output register.
// ----------------------------------------------------------------------------
module blg_dp #(
  parameter int COORD_BITS = blg_pkg::COORD_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire blg_pkg::blg_cmd_t              cmd,
  output blg_pkg::blg_sts_t                   sts,
  input  wire logic [COORD_BITS-1:0]          in_start_x,
  input  wire logic [COORD_BITS-1:0]          in_start_y,
  input  wire logic [COORD_BITS-1:0]          in_end_x,
  input  wire logic [COORD_BITS-1:0]          in_end_y,
  input  wire logic [blg_pkg::COLOR_BITS-1:0] in_line_color,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [COORD_BITS-1:0]               out_pixel_x,
  output logic [COORD_BITS-1:0]               out_pixel_y,
  output logic [blg_pkg::COLOR_BITS-1:0]      out_pixel_color,
  output logic                                out_last_pixel
);
  import blg_pkg::*;

  localparam int EW = COORD_BITS + 3;
  localparam logic [COORD_BITS-1:0] ONE = COORD_BITS'(1);

  // latched command
  logic [COORD_BITS-1:0] ax_r, ay_r, bx_r, by_r;
  logic [COLOR_BITS-1:0] color_r;

  // walk state
  logic [COORD_BITS-1:0] major_pos_r, minor_pos_r, major_end_r;
  logic [COORD_BITS-1:0] d_maj_r, d_min_r;
  logic signed [EW-1:0]  err_r;
  logic                  step_down_r, x_major_r;

  // output register
  logic                  out_valid_r;
  logic [COORD_BITS-1:0] out_x_r, out_y_r;
  logic [COLOR_BITS-1:0] out_color_r;
  logic                  out_last_r;

  // setup logic
  logic [COORD_BITS-1:0] adx, ady;
  logic                  x_major;
  logic [COORD_BITS-1:0] s_maj, s_min, e_maj, e_min;
  logic [COORD_BITS-1:0] o_smaj, o_smin, o_emaj, o_emin;
  logic                  down;
  logic [COORD_BITS-1:0] d_maj, d_min;
  logic signed [EW-1:0]  err_init;

  // walk logic
  logic signed [EW-1:0]  two_dmin, two_dmaj, err_nxt;
  logic                  err_pos;

  always_comb begin
    adx     = (bx_r > ax_r) ? bx_r - ax_r : ax_r - bx_r;
    ady     = (by_r > ay_r) ? by_r - ay_r : ay_r - by_r;
    x_major = adx > ady;
    if (x_major) begin
      s_maj = ax_r; s_min = ay_r; e_maj = bx_r; e_min = by_r;
    end else begin
      s_maj = ay_r; s_min = ax_r; e_maj = by_r; e_min = bx_r;
    end
    // order so the major coordinate rises
    if (s_maj > e_maj) begin
      o_smaj = e_maj; o_smin = e_min; o_emaj = s_maj; o_emin = s_min;
    end else begin
      o_smaj = s_maj; o_smin = s_min; o_emaj = e_maj; o_emin = e_min;
    end
    d_maj    = o_emaj - o_smaj;
    down     = o_emin < o_smin;
    d_min    = down ? o_smin - o_emin : o_emin - o_smin;
    err_init = signed'({2'b00, d_min, 1'b0}) - signed'({3'b000, d_maj});
  end

  always_comb begin
    two_dmin = signed'({2'b00, d_min_r, 1'b0});
    two_dmaj = signed'({2'b00, d_maj_r, 1'b0});
    err_pos  = !err_r[EW-1];
    err_nxt  = err_pos ? err_r + two_dmin - two_dmaj : err_r + two_dmin;
  end

  assign sts.zero_len = (adx == '0) && (ady == '0);
  assign sts.at_end   = (major_pos_r == major_end_r);
  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax_r    <= in_start_x;
      ay_r    <= in_start_y;
      bx_r    <= in_end_x;
      by_r    <= in_end_y;
      color_r <= in_line_color;
    end
    if (cmd.setup) begin
      major_pos_r <= o_smaj;
      minor_pos_r <= o_smin;
      major_end_r <= o_emaj;
      d_maj_r     <= d_maj;
      d_min_r     <= d_min;
      err_r       <= err_init;
      step_down_r <= down;
      x_major_r   <= x_major;
    end else if (cmd.step) begin
      out_x_r     <= x_major_r ? major_pos_r : minor_pos_r;
      out_y_r     <= x_major_r ? minor_pos_r : major_pos_r;
      out_color_r <= color_r;
      out_last_r  <= sts.at_end;
      if (err_pos) begin
        minor_pos_r <= step_down_r ? minor_pos_r - ONE : minor_pos_r + ONE;
      end
      err_r       <= err_nxt;
      major_pos_r <= major_pos_r + ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = out_x_r;
  assign out_pixel_y     = out_y_r;
  assign out_pixel_color = out_color_r;
  assign out_last_pixel  = out_last_r;

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the line pixel generator: feeds line words from a
// directed table and then at random, takes typed pixels or predicts them with
// its own Bresenham walk, and compares each emitted pixel word field by field.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CB = blg_pkg::COORD_BITS_DEF;
  localparam int COLB = blg_pkg::COLOR_BITS;
  localparam int RANDOM_LINES = 450;
  localparam int IDLE_PCT = 24;
  // Random lines that run with both sides at full rate
  localparam int BURST_FIRST = 150;
  localparam int BURST_LAST = 260;
  localparam int TAIL_CYCLES = 12;

  typedef struct packed {
    logic [CB-1:0]   sx;
    logic [CB-1:0]   sy;
    logic [CB-1:0]   ex;
    logic [CB-1:0]   ey;
    logic [COLB-1:0] color;
  } line_t;

  typedef struct packed {
    logic [CB-1:0]   x;
    logic [CB-1:0]   y;
    logic [COLB-1:0] color;
    logic            last;
  } pixel_t;

  // One row of the directed table; n_typed < 0 leaves the pixels to the walk
  typedef struct {
    line_t  cmd;
    int     n_typed;
    pixel_t typed[2];
  } row_t;

  logic clk;
  logic rst_n;

  blg_line_if  #(.COORD_BITS(CB)) line_ch ();
  blg_pixel_if #(.COORD_BITS(CB)) pix_ch ();

  bresenham_line_pixel_generator #(.COORD_BITS(CB)) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_line (line_ch.sink),
    .out_pix (pix_ch.source)
  );

  // Pixels still owed by the block, oldest first
  pixel_t pending_pixels[$];
  row_t   line_table[$];
  int     mismatch_count = 0;
  int     src_idle_pct = IDLE_PCT;
  int     snk_idle_pct = IDLE_PCT;

  // Walk state of the predictor, kept at the block's widths
  logic [CB-1:0]     walk_major;
  logic [CB-1:0]     walk_minor;
  logic [CB-1:0]     walk_end;
  logic signed [8:0] walk_err;
  bit                walk_step_down;
  bit                walk_x_major;
  logic [COLB-1:0]   walk_color;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Walk one line with the integer error term and queue its pixels.
  task automatic trace_line(input line_t l, ref pixel_t q[$]);
    int     ax, ay, bx, by, adx, ady;
    int     s_maj, s_min, e_maj, e_min, d_maj, d_min, t;
    bit     last;
    pixel_t p;
    ax = int'(l.sx);
    ay = int'(l.sy);
    bx = int'(l.ex);
    by = int'(l.ey);
    adx = (bx > ax) ? bx - ax : ax - bx;
    ady = (by > ay) ? by - ay : ay - by;
    walk_color = l.color;
    // Equal spans fall to the y-major walk
    walk_x_major = adx > ady;
    if (walk_x_major) begin
      s_maj = ax; s_min = ay; e_maj = bx; e_min = by;
    end else begin
      s_maj = ay; s_min = ax; e_maj = by; e_min = bx;
    end
    // Swap the endpoints so the major coordinate only ever rises
    if (s_maj > e_maj) begin
      t = s_maj; s_maj = e_maj; e_maj = t;
      t = s_min; s_min = e_min; e_min = t;
    end
    d_maj = e_maj - s_maj;
    d_min = e_min - s_min;
    walk_step_down = d_min < 0;
    if (walk_step_down) d_min = -d_min;
    // A line whose endpoints coincide gives no pixel at all
    if (d_maj == 0) return;
    walk_major = CB'(s_maj);
    walk_minor = CB'(s_min);
    walk_end   = CB'(e_maj);
    walk_err   = 9'(2 * d_min - d_maj);
    forever begin
      last = walk_major == walk_end;
      p.x     = walk_x_major ? walk_major : walk_minor;
      p.y     = walk_x_major ? walk_minor : walk_major;
      p.color = walk_color;
      p.last  = last;
      q.push_back(p);
      if (walk_err >= 0) begin
        walk_minor = walk_step_down ? walk_minor - 1'b1 : walk_minor + 1'b1;
        walk_err   = 9'(walk_err - 2 * d_maj);
      end
      walk_err = 9'(walk_err + 2 * d_min);
      if (last) break;
      walk_major = walk_major + 1'b1;
    end
  endtask

  function automatic line_t mk_line(int sx, int sy, int ex, int ey, logic [COLB-1:0] c);
    line_t l;
    l.sx = CB'(sx);
    l.sy = CB'(sy);
    l.ex = CB'(ex);
    l.ey = CB'(ey);
    l.color = c;
    return l;
  endfunction

  function automatic pixel_t mk_px(int x, int y, logic [COLB-1:0] c, int last);
    pixel_t p;
    p.x = CB'(x);
    p.y = CB'(y);
    p.color = c;
    p.last = (last != 0);
    return p;
  endfunction

  function automatic void add_row(line_t cmd, int n, pixel_t p0, pixel_t p1);
    row_t r;
    r.cmd = cmd;
    r.n_typed = n;
    r.typed[0] = p0;
    r.typed[1] = p1;
    line_table.push_back(r);
  endfunction

  // Offer one line word, idling at random first, and hold it until taken.
  // On acceptance queue its pixels: typed ones if given, else predicted.
  task automatic issue_line(input line_t l, input int n_typed, input pixel_t typed[2]);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      line_ch.valid = 1'b0;
      @(negedge clk);
    end
    line_ch.valid      = 1'b1;
    line_ch.start_x    = l.sx;
    line_ch.start_y    = l.sy;
    line_ch.end_x      = l.ex;
    line_ch.end_y      = l.ey;
    line_ch.line_color = l.color;
    @(posedge clk);
    while (!line_ch.ready) @(posedge clk);
    if (n_typed < 0) begin
      trace_line(l, pending_pixels);
    end else begin
      for (int i = 0; i < n_typed; i++) pending_pixels.push_back(typed[i]);
    end
  endtask

  // Output side: drop ready at random, always on the falling edge
  always @(negedge clk) begin
    pix_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Compare every accepted pixel word with the oldest one owed
  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && pix_ch.valid && pix_ch.ready) begin
      if (pending_pixels.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected pixel x=%0d y=%0d color=%h last=%b", $time,
                 pix_ch.pixel_x, pix_ch.pixel_y, pix_ch.pixel_color, pix_ch.last_pixel);
      end else begin
        want = pending_pixels.pop_front();
        if (pix_ch.pixel_x !== want.x) begin
          mismatch_count++;
          $display("%0t: pixel_x expected %0d actual %0d", $time, want.x, pix_ch.pixel_x);
        end
        if (pix_ch.pixel_y !== want.y) begin
          mismatch_count++;
          $display("%0t: pixel_y expected %0d actual %0d", $time, want.y, pix_ch.pixel_y);
        end
        if (pix_ch.pixel_color !== want.color) begin
          mismatch_count++;
          $display("%0t: pixel_color expected %h actual %h", $time, want.color,
                   pix_ch.pixel_color);
        end
        if (pix_ch.last_pixel !== want.last) begin
          mismatch_count++;
          $display("%0t: last_pixel expected %b actual %b", $time, want.last,
                   pix_ch.last_pixel);
        end
      end
    end
  end

  // Main sequence: reset, directed table, random lines, drain
  initial begin
    pixel_t no_px[2];
    pixel_t nil;
    line_t  l;
    int     pick;
    int     span;
    nil = '0;
    no_px[0] = nil;
    no_px[1] = nil;

    line_ch.valid      = 1'b0;
    line_ch.start_x    = '0;
    line_ch.start_y    = '0;
    line_ch.end_x      = '0;
    line_ch.end_y      = '0;
    line_ch.line_color = '0;
    pix_ch.ready       = 1'b0;
    rst_n              = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Zero-length lines at both corners: nothing comes out
    add_row(mk_line(0, 0, 0, 0, 32'h0000_0000), 0, nil, nil);
    add_row(mk_line(63, 63, 63, 63, 32'hFFFF_FFFF), 0, nil, nil);
    // One-step lines, read straight off the walk
    add_row(mk_line(0, 0, 1, 0, 32'hFFFF_FFFF), 2,
            mk_px(0, 0, 32'hFFFF_FFFF, 0), mk_px(1, 0, 32'hFFFF_FFFF, 1));
    // Reversed endpoints come out in rising major order
    add_row(mk_line(1, 0, 0, 0, 32'h0000_0000), 2,
            mk_px(0, 0, 32'h0000_0000, 0), mk_px(1, 0, 32'h0000_0000, 1));
    add_row(mk_line(63, 63, 63, 62, 32'hFFFF_FFFF), 2,
            mk_px(63, 62, 32'hFFFF_FFFF, 0), mk_px(63, 63, 32'hFFFF_FFFF, 1));
    // Short diagonals walk y-major, minor stepping up and down
    add_row(mk_line(0, 0, 1, 1, 32'hA5A5_5A5A), 2,
            mk_px(0, 0, 32'hA5A5_5A5A, 0), mk_px(1, 1, 32'hA5A5_5A5A, 1));
    add_row(mk_line(63, 0, 62, 1, 32'h5A5A_A5A5), 2,
            mk_px(63, 0, 32'h5A5A_A5A5, 0), mk_px(62, 1, 32'h5A5A_A5A5, 1));
    // Full-span and shaped lines, left to the predictor
    add_row(mk_line(0, 0, 63, 0, 32'hFFFF_FFFF), -1, nil, nil);
    add_row(mk_line(0, 63, 0, 0, 32'h0000_0000), -1, nil, nil);
    add_row(mk_line(0, 0, 63, 63, 32'hAAAA_AAAA), -1, nil, nil);
    add_row(mk_line(63, 0, 0, 63, 32'h5555_5555), -1, nil, nil);
    add_row(mk_line(0, 63, 63, 0, 32'h1234_5678), -1, nil, nil);
    add_row(mk_line(63, 63, 0, 0, 32'h8765_4321), -1, nil, nil);
    add_row(mk_line(0, 0, 63, 1, 32'hDEAD_BEEF), -1, nil, nil);
    add_row(mk_line(5, 0, 4, 63, 32'hCAFE_F00D), -1, nil, nil);
    add_row(mk_line(63, 62, 0, 63, 32'h0F0F_0F0F), -1, nil, nil);
    add_row(mk_line(10, 20, 50, 35, 32'hF0F0_F0F0), -1, nil, nil);
    add_row(mk_line(50, 35, 10, 20, 32'h00FF_00FF), -1, nil, nil);
    add_row(mk_line(2, 3, 3, 5, 32'hFF00_FF00), -1, nil, nil);
    add_row(mk_line(31, 17, 31, 17, 32'h0000_0001), -1, nil, nil);
    add_row(mk_line(40, 8, 9, 44, 32'h8000_0000), -1, nil, nil);

    foreach (line_table[i]) issue_line(line_table[i].cmd, line_table[i].n_typed,
                                       line_table[i].typed);

    for (int n = 0; n < RANDOM_LINES; n++) begin
      // Run a long stretch with neither side idling
      if (n == BURST_FIRST) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      if (n == BURST_LAST) begin
        src_idle_pct = IDLE_PCT;
        snk_idle_pct = IDLE_PCT;
      end
      l.sx    = CB'($urandom);
      l.sy    = CB'($urandom);
      l.color = $urandom;
      pick    = $urandom_range(99);
      if (pick < 12) begin
        // coincident endpoints
        l.ex = l.sx;
        l.ey = l.sy;
      end else if (pick < 40) begin
        // short lines, up to three steps either way on each axis
        l.ex = l.sx + CB'($urandom_range(6)) - CB'(3);
        l.ey = l.sy + CB'($urandom_range(6)) - CB'(3);
      end else if (pick < 55) begin
        // axis-aligned and exact diagonals
        span = $urandom_range(63);
        case ($urandom_range(2))
          0: begin
            l.ex = CB'(span);
            l.ey = l.sy;
          end
          1: begin
            l.ex = l.sx;
            l.ey = CB'(span);
          end
          default: begin
            l.ex = l.sx + CB'(span);
            l.ey = ($urandom_range(1) == 0) ? l.sy + CB'(span) : l.sy - CB'(span);
          end
        endcase
      end else begin
        l.ex = CB'($urandom);
        l.ey = CB'($urandom);
      end
      issue_line(l, -1, no_px);
    end

    @(negedge clk);
    line_ch.valid = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest legal run
  initial begin
    #1_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
